// ===== src/pklt_pkg.sv =====
// Package: shared types, codes and constants of the peer keepalive latency tracker.
package pklt_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned LAT_W       = 8;
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [DATA_W-1:0] LATENCY_CAP = 32'd255;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PONG = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PING = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_UNGRANTED_ROUTE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANTED_ROUTE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_GAP        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT   = 8'd3;

  localparam logic [DATA_W-1:0] RST_UNGRANTED_ROUTE = 32'd20;
  localparam logic [DATA_W-1:0] RST_GRANTED_ROUTE   = 32'd160;
  localparam logic [DATA_W-1:0] RST_PING_GAP        = 32'd80;
  localparam logic [DATA_W-1:0] RST_SILENCE_LIMIT   = 32'd640;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SUM,
    ST_DIV,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] now;
    logic [DATA_W-1:0] msg_id;
    logic              has_deny;
    logic              is_negative;
    logic              has_grant;
    logic [DATA_W-1:0] next_ping_id;
  } in_item_t;

  typedef struct packed {
    logic              send_ping;
    logic              send_pong;
    logic [DATA_W-1:0] reply_id;
    logic              send_routes;
    logic              mark_negative;
    logic              pong_accepted;
    logic [DATA_W-1:0] avg_latency;
    logic [LAT_W-1:0]  route_latency;
  } out_item_t;

  function automatic logic [LAT_W-1:0] sat_latency(input logic [DATA_W-1:0] lat);
    logic [LAT_W-1:0] r;
    if (lat <= LATENCY_CAP) r = lat[LAT_W-1:0];
    else r = LATENCY_CAP[LAT_W-1:0];
    return r;
  endfunction

endpackage

// ===== src/pklt_in_if.sv =====
// Interface: input event channel, valid/ready with one event item.
interface pklt_in_if;
  logic               valid;
  logic               ready;
  pklt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pklt_out_if.sv =====
// Interface: result channel, valid/ready with one result item.
interface pklt_out_if;
  logic                valid;
  logic                ready;
  pklt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pklt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pklt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/peer_keepalive_latency_tracker.sv =====
// Top level: keepalive engine and round-trip latency averager for one peer.
//
// Channels: req (sink) takes one event per transaction: an update tick, a
// received pong or a received ping, with the current tick count and the
// peer flags. rsp (source) gives exactly one result per event, in order.
// Configuration: cfg_we/cfg_index/cfg_wdata write the four interval and
// silence registers; indexes beyond the list are dropped. Write only while
// the block is idle.
//
// Sequencing: one event at a time. A tick, a ping, a pong that does not
// match, or an unused command passes through execute (EXEC) and output load
// (PUT); the block then returns to idle and takes the next event. A matching
// pong adds a read-modify-write step (SUM) that retires the oldest sample and
// updates the running sum, and a step (DIV) that divides the sum by
// NUM_SAMPLES, the ring depth, with a reciprocal multiply.
//
// The round-trip samples sit in a NUM_SAMPLES-deep RAM used as a ring; a
// wrap flag makes slots never written read as zero, so reset needs no clear
// pass. Reset loads the register defaults and clears all tracker state.
// A stalled receiver holds the result in the output register; the block
// still accepts and processes the next event, and waits before its own
// output load until the register frees up.
module peer_keepalive_latency_tracker #(
  parameter int unsigned NUM_SAMPLES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  pklt_in_if.sink                              req,
  pklt_out_if.source                           rsp,
  input  logic                                 cfg_we,
  input  logic [pklt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pklt_pkg::DATA_W-1:0]          cfg_wdata
);
  localparam int unsigned DW      = pklt_pkg::DATA_W;
  localparam int unsigned PTR_W   = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam int unsigned LOG_N   = $clog2(NUM_SAMPLES);
  localparam int unsigned RECIP_W = DW + 1;
  localparam int unsigned WIDE_W  = 2 * DW;
  localparam int unsigned PROD_W  = 2 * DW + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_SAMPLES - 1);
  // floor(2^(DW+LOG_N) / NUM_SAMPLES) + 1 gives the exact quotient of any DW-bit sum.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << (DW + LOG_N)) / 64'(NUM_SAMPLES)) + 64'd1);

  pklt_pkg::state_t state, state_next;

  // Configuration registers
  logic [DW-1:0] plain_route_gap;
  logic [DW-1:0] grant_route_gap;
  logic [DW-1:0] ping_gap;
  logic [DW-1:0] silence_limit;

  // Tracker state
  logic [DW-1:0] ping_id_current;
  logic          ping_in_flight;
  logic [DW-1:0] last_pong_time;
  logic [DW-1:0] last_ping_time;
  logic [DW-1:0] last_route_time;
  logic [DW-1:0] mean_latency;
  logic [DW-1:0] sample_sum;
  logic [PTR_W-1:0] wr_ptr;
  logic          wrapped;

  // Working registers (payload)
  pklt_pkg::in_item_t  item;
  pklt_pkg::out_item_t res;
  pklt_pkg::out_item_t rsp_data;
  pklt_pkg::out_item_t rsp_load;
  logic                rsp_valid;
  logic [DW-1:0]       rtt;
  logic [DW-1:0]       div_dvd;

  // RAM
  logic [DW-1:0] ram_rdata;
  logic          ram_we;

  // Execute-stage decode
  logic          tick_live;
  logic          silence_over;
  logic          route_due;
  logic          ping_due;
  logic          do_route;
  logic          do_ping;
  logic          is_ping;
  logic          pong_match;
  logic [DW-1:0] route_iv;
  pklt_pkg::out_item_t res_exec;

  // Sum and divide step
  logic [DW-1:0]     old_sample;
  logic [DW-1:0]     sum_new;
  logic [WIDE_W-1:0] prod_lo;
  logic [PROD_W-1:0] div_prod;
  logic [DW-1:0]     div_quot;

  logic rsp_free;

  assign req.ready = (state == pklt_pkg::ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
  assign rsp_free  = !rsp_valid || rsp.ready;

  pklt_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_SAMPLES)
  ) u_samples (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (rtt),
    .raddr (wr_ptr),
    .rdata (ram_rdata)
  );

  // Decode the held event against current state.
  always_comb begin
    route_iv     = item.has_grant ? grant_route_gap : plain_route_gap;
    tick_live    = (item.cmd == pklt_pkg::CMD_TICK) && !item.has_deny && !item.is_negative;
    silence_over = (item.now - last_pong_time) > silence_limit;
    route_due    = (item.now - last_route_time) >= route_iv;
    ping_due     = (item.now - last_ping_time) >= ping_gap;
    do_route     = tick_live && !silence_over && route_due;
    do_ping      = tick_live && !silence_over && ping_due;
    is_ping      = (item.cmd == pklt_pkg::CMD_PING);
    pong_match   = (item.cmd == pklt_pkg::CMD_PONG) && ping_in_flight &&
                   (item.msg_id == ping_id_current);

    res_exec               = '0;
    res_exec.send_ping     = do_ping;
    res_exec.send_pong     = is_ping;
    res_exec.send_routes   = do_route;
    res_exec.mark_negative = tick_live && silence_over;
    res_exec.pong_accepted = pong_match;
    if (do_ping) begin
      res_exec.reply_id = item.next_ping_id;
    end else if (is_ping) begin
      res_exec.reply_id = item.msg_id;
    end
  end

  // Retire the oldest sample and fold in the new one; wrap matches the full sum.
  always_comb begin
    old_sample = wrapped ? ram_rdata : '0;
    sum_new    = sample_sum - old_sample + rtt;
    ram_we     = (state == pklt_pkg::ST_SUM);
  end

  // Divide by NUM_SAMPLES: multiply by the reciprocal, keep the top bits.
  // The reciprocal's top bit adds the sum shifted up by DW.
  always_comb begin
    prod_lo  = WIDE_W'(div_dvd) * WIDE_W'(RECIP[DW-1:0]);
    div_prod = {1'b0, prod_lo} + (RECIP[DW] ? {1'b0, div_dvd, {DW{1'b0}}} : '0);
    div_quot = DW'(div_prod >> (DW + LOG_N));
  end

  // Result as loaded into the output register.
  always_comb begin
    rsp_load               = res;
    rsp_load.avg_latency   = mean_latency;
    rsp_load.route_latency = pklt_pkg::sat_latency(mean_latency);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pklt_pkg::ST_IDLE: begin
        if (req.valid) state_next = pklt_pkg::ST_EXEC;
      end
      pklt_pkg::ST_EXEC: begin
        state_next = pong_match ? pklt_pkg::ST_SUM : pklt_pkg::ST_PUT;
      end
      pklt_pkg::ST_SUM: begin
        state_next = pklt_pkg::ST_DIV;
      end
      pklt_pkg::ST_DIV: begin
        state_next = pklt_pkg::ST_PUT;
      end
      pklt_pkg::ST_PUT: begin
        if (rsp_free) state_next = pklt_pkg::ST_IDLE;
      end
      default: state_next = pklt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pklt_pkg::ST_IDLE;
      plain_route_gap <= pklt_pkg::RST_UNGRANTED_ROUTE;
      grant_route_gap <= pklt_pkg::RST_GRANTED_ROUTE;
      ping_gap        <= pklt_pkg::RST_PING_GAP;
      silence_limit   <= pklt_pkg::RST_SILENCE_LIMIT;
      ping_id_current <= '0;
      ping_in_flight  <= 1'b0;
      last_pong_time  <= '0;
      last_ping_time  <= '0;
      last_route_time <= '0;
      mean_latency    <= '0;
      sample_sum      <= '0;
      wr_ptr          <= '0;
      wrapped         <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        if (cfg_index == pklt_pkg::CFG_UNGRANTED_ROUTE) plain_route_gap <= cfg_wdata;
        if (cfg_index == pklt_pkg::CFG_GRANTED_ROUTE)   grant_route_gap <= cfg_wdata;
        if (cfg_index == pklt_pkg::CFG_PING_GAP)        ping_gap        <= cfg_wdata;
        if (cfg_index == pklt_pkg::CFG_SILENCE_LIMIT)   silence_limit   <= cfg_wdata;
      end

      // Raise valid on an output load; drop it once the result is taken.
      if (state == pklt_pkg::ST_PUT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        pklt_pkg::ST_IDLE: begin
        end
        pklt_pkg::ST_EXEC: begin
          if (do_route) last_route_time <= item.now;
          if (do_ping) begin
            ping_id_current <= item.next_ping_id;
            ping_in_flight  <= 1'b1;
            last_ping_time  <= item.now;
          end
          if (pong_match) begin
            ping_in_flight <= 1'b0;
            last_pong_time <= item.now;
          end
        end
        pklt_pkg::ST_SUM: begin
          sample_sum <= sum_new;
          wr_ptr     <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
          if (wr_ptr == PTR_LAST) wrapped <= 1'b1;
        end
        pklt_pkg::ST_DIV: begin
          mean_latency <= div_quot;
        end
        pklt_pkg::ST_PUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (state == pklt_pkg::ST_IDLE && req.valid) begin
      item <= req.data;
    end
    if (state == pklt_pkg::ST_EXEC) begin
      res <= res_exec;
      rtt <= item.now - last_ping_time;
    end
    if (state == pklt_pkg::ST_SUM) begin
      div_dvd <= sum_new;
    end
    if (state == pklt_pkg::ST_PUT && rsp_free) begin
      rsp_data <= rsp_load;
    end
  end

endmodule

// ===== src/pklt_checker.sv =====
// Checker: port-level properties of the keepalive tracker, bound to the top level.
module pklt_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input pklt_pkg::out_item_t out_data
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_no_valid_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_idle_reply_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.send_ping && !out_data.send_pong |-> out_data.reply_id == '0)
    else $error("reply id set with nothing sent");

  a_route_latency_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.route_latency ==
      pklt_pkg::sat_latency(out_data.avg_latency))
    else $error("route latency does not match mean");

  a_exclusive_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.mark_negative || out_data.send_pong || out_data.pong_accepted)
      |-> !out_data.send_ping && !out_data.send_routes)
    else $error("tick sends combined with another event kind");

endmodule

bind peer_keepalive_latency_tracker pklt_checker u_pklt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_data  (rsp.data)
);
